@@ rtl/core/c3s_pkg.sv @@
// ----------------------------------------------------------------------------
// c3s_pkg
// shared types, widths and register codes of the 3x3 stencil stream unit
// ----------------------------------------------------------------------------
package c3s_pkg;

    // fixed field widths
    localparam int SAMPLE_BITS   = 16;
    localparam int KERNEL_SIZE   = 3;
    localparam int COEF_BITS     = 16;
    localparam int ACC_BITS      = 32;
    localparam int ROW_BITS      = 16;
    localparam int OCOL_BITS     = 10;
    localparam int LW_BITS       = 11;
    localparam int CFG_DATA_BITS = 48;
    localparam int CFG_ADDR_BITS = 3;
    localparam int M_TDATA_BITS  = 64;
    localparam int M_FIELD_BITS  = ACC_BITS + ROW_BITS + OCOL_BITS;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // register indexes
    localparam logic [CFG_ADDR_BITS-1:0] CFG_COEF_TOP     = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_COEF_MID     = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_COEF_BOT     = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_LINE_WIDTH   = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_IMAGE_HEIGHT = 3'd4;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [ACC_BITS-1:0]    acc_t;

    // window[r][c]: r = 0 top row, c = 0 left column
    typedef sample_t [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0] window_t;

    // coefficient rows, index 0 = top
    typedef logic [KERNEL_SIZE-1:0][CFG_DATA_BITS-1:0] coef_set_t;

    typedef struct packed {
        logic                 last;
        logic [OCOL_BITS-1:0] out_col;
        logic [ROW_BITS-1:0]  out_row;
    } result_meta_t;

    typedef struct packed {
        window_t      win;
        result_meta_t meta;
    } q_entry_t;

    typedef struct packed {
        logic [QCNT_BITS-1:0] count;
        logic                 full;
        logic                 empty;
    } q_status_t;

    // signed coefficient at position pos of a packed row, left first
    function automatic logic signed [COEF_BITS-1:0] coef_at(
        input logic [CFG_DATA_BITS-1:0] row,
        input int                       pos
    );
        coef_at = row[pos*COEF_BITS +: COEF_BITS];
    endfunction

endpackage

@@ rtl/core/c3s_ram.sv @@
// ----------------------------------------------------------------------------
// c3s_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module c3s_ram #(
    parameter int WIDTH     = 16,
    parameter int DEPTH     = 1024,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/c3s_front.sv @@
// ----------------------------------------------------------------------------
// c3s_front
// accepts samples, tracks row and column, runs the line stores and window
// ----------------------------------------------------------------------------
module c3s_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  c3s_pkg::sample_t              in_sample,
    input  logic                          in_img_start,
    input  logic [c3s_pkg::LW_BITS-1:0]   line_width,
    input  logic [c3s_pkg::ROW_BITS-1:0]  image_height,
    output logic                          out_valid,
    input  logic                          out_ready,
    output c3s_pkg::q_entry_t             out_entry
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = $clog2(MAX_WIDTH + 1);
    localparam int K  = c3s_pkg::KERNEL_SIZE;

    logic [EW-1:0]                  eff_width;
    logic [CW-1:0]                  col_reg, col_next;
    logic [c3s_pkg::ROW_BITS-1:0]   row_reg, row_next;
    logic [CW-1:0]                  col_start, col_cur;
    logic [c3s_pkg::ROW_BITS-1:0]   row_cur;
    logic                           col_wrap, row_wrap, emit, accept;
    c3s_pkg::result_meta_t          meta_cur;

    // second stage, holds the item while the line store read completes
    logic                           f1_valid_reg, f1_valid_next;
    c3s_pkg::sample_t               f1_sample_reg;
    logic [CW-1:0]                  f1_addr_reg;
    logic                           f1_emit_reg;
    c3s_pkg::result_meta_t          f1_meta_reg;
    logic                           fwd_reg;
    c3s_pkg::sample_t               fwd_upper_reg, fwd_lower_reg;
    logic                           f1_adv;

    logic [c3s_pkg::SAMPLE_BITS-1:0] upper_q, lower_q;
    c3s_pkg::sample_t               upper_col, lower_col;
    c3s_pkg::window_t               win_reg, win_shift;

    // effective width: clamp to store depth, zero acts as one
    always_comb begin
        if (32'(line_width) > 32'(MAX_WIDTH)) begin
            eff_width = EW'(MAX_WIDTH);
        end else if (line_width == '0) begin
            eff_width = EW'(1);
        end else begin
            eff_width = EW'(line_width);
        end
    end

    always_comb begin
        col_start = in_img_start ? '0 : col_reg;
        row_cur   = in_img_start ? '0 : row_reg;
        col_cur   = (EW'(col_start) >= eff_width) ? '0 : col_start;
        col_wrap  = (EW'(col_cur) + EW'(1)) >= eff_width;
        row_wrap  = (17'(row_cur) + 17'd1) >= 17'(image_height);
        emit      = (row_cur >= 16'd2) && (col_cur >= CW'(2));
        meta_cur.out_row = row_cur - 16'd2;
        meta_cur.out_col = c3s_pkg::OCOL_BITS'(col_cur - CW'(2));
        meta_cur.last    = (image_height != '0) && (row_cur == image_height - 16'd1)
                           && col_wrap;
    end

    always_comb begin
        f1_adv   = f1_valid_reg && (!f1_emit_reg || out_ready);
        in_ready = !f1_valid_reg || f1_adv;
        accept   = in_valid && in_ready;

        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_wrap) begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_cur + 16'd1;
            end else begin
                col_next = col_cur + CW'(1);
                row_next = row_cur;
            end
        end

        if (accept) begin
            f1_valid_next = 1'b1;
        end else if (f1_adv) begin
            f1_valid_next = 1'b0;
        end else begin
            f1_valid_next = f1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            f1_valid_reg <= 1'b0;
            win_reg      <= '0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            f1_valid_reg <= f1_valid_next;
            if (f1_adv) begin
                win_reg <= win_shift;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            f1_sample_reg <= in_sample;
            f1_addr_reg   <= col_cur;
            f1_emit_reg   <= emit;
            f1_meta_reg   <= meta_cur;
            // same address written this cycle: the ram returns the old word
            fwd_reg       <= f1_adv && (f1_addr_reg == col_cur);
            fwd_upper_reg <= lower_col;
            fwd_lower_reg <= f1_sample_reg;
        end
    end

    c3s_ram #(
        .WIDTH (c3s_pkg::SAMPLE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_upper_store (
        .aclk  (aclk),
        .we    (f1_adv),
        .waddr (f1_addr_reg),
        .wdata (lower_col),
        .re    (accept),
        .raddr (col_cur),
        .rdata (upper_q)
    );

    c3s_ram #(
        .WIDTH (c3s_pkg::SAMPLE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_lower_store (
        .aclk  (aclk),
        .we    (f1_adv),
        .waddr (f1_addr_reg),
        .wdata (f1_sample_reg),
        .re    (accept),
        .raddr (col_cur),
        .rdata (lower_q)
    );

    always_comb begin
        upper_col = fwd_reg ? fwd_upper_reg : $signed(upper_q);
        lower_col = fwd_reg ? fwd_lower_reg : $signed(lower_q);
        for (int r = 0; r < K; r++) begin
            for (int c = 0; c < K - 1; c++) begin
                win_shift[r][c] = win_reg[r][c+1];
            end
        end
        win_shift[0][K-1] = upper_col;
        win_shift[1][K-1] = lower_col;
        win_shift[2][K-1] = f1_sample_reg;
    end

    assign out_valid      = f1_valid_reg && f1_emit_reg;
    assign out_entry.win  = win_shift;
    assign out_entry.meta = f1_meta_reg;

endmodule

@@ rtl/core/c3s_queue.sv @@
// ----------------------------------------------------------------------------
// c3s_queue
// short fifo of windows between front and back
// ----------------------------------------------------------------------------
module c3s_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  c3s_pkg::q_entry_t   in_entry,
    output logic                out_valid,
    input  logic                out_ready,
    output c3s_pkg::q_entry_t   out_entry,
    output c3s_pkg::q_status_t  status
);

    localparam int D = c3s_pkg::QUEUE_DEPTH;

    c3s_pkg::q_entry_t                 slot_reg [D];
    logic [c3s_pkg::QPTR_BITS-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [c3s_pkg::QPTR_BITS-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [c3s_pkg::QCNT_BITS-1:0]     count_reg, count_next;
    logic                              push, pop;

    always_comb begin
        in_ready  = count_reg != c3s_pkg::QCNT_BITS'(D);
        out_valid = count_reg != '0;
        push      = in_valid && in_ready;
        pop       = out_valid && out_ready;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == c3s_pkg::QPTR_BITS'(D - 1)) ? '0
                          : wr_ptr_reg + c3s_pkg::QPTR_BITS'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == c3s_pkg::QPTR_BITS'(D - 1)) ? '0
                          : rd_ptr_reg + c3s_pkg::QPTR_BITS'(1);
        end
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + c3s_pkg::QCNT_BITS'(1);
        end else if (pop && !push) begin
            count_next = count_reg - c3s_pkg::QCNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_entry;
        end
    end

    assign out_entry    = slot_reg[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.full  = !in_ready;
    assign status.empty = !out_valid;

endmodule

@@ rtl/core/c3s_back.sv @@
// ----------------------------------------------------------------------------
// c3s_back
// multiply-accumulate pipeline: products, row sums, final sum into output
// ----------------------------------------------------------------------------
module c3s_back (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  c3s_pkg::q_entry_t                    in_entry,
    input  c3s_pkg::coef_set_t                   coefs,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [c3s_pkg::M_TDATA_BITS-1:0]     m_tdata,
    output logic                                 m_tlast
);

    localparam int K = c3s_pkg::KERNEL_SIZE;

    typedef c3s_pkg::acc_t [K-1:0][K-1:0] prod_t;
    typedef c3s_pkg::acc_t [K-1:0]        rsum_t;

    logic                    s1_valid_reg, s2_valid_reg, out_valid_reg;
    prod_t                   prod_reg, prod_next;
    rsum_t                   rsum_reg, rsum_next;
    c3s_pkg::acc_t           value_reg, value_next;
    c3s_pkg::result_meta_t   meta1_reg, meta2_reg, meta3_reg;
    logic                    out_free, s2_free, s1_free;

    always_comb begin
        out_free = !out_valid_reg || m_tready;
        s2_free  = !s2_valid_reg || out_free;
        s1_free  = !s1_valid_reg || s2_free;
        in_ready = s1_free;
    end

    // one multiplier per tap
    always_comb begin
        c3s_pkg::acc_t ce;
        c3s_pkg::acc_t se;
        for (int r = 0; r < K; r++) begin
            for (int c = 0; c < K; c++) begin
                ce = c3s_pkg::ACC_BITS'($signed(c3s_pkg::coef_at(coefs[r], c)));
                se = c3s_pkg::ACC_BITS'($signed(in_entry.win[r][c]));
                prod_next[r][c] = ce * se;
            end
        end
    end

    always_comb begin
        for (int r = 0; r < K; r++) begin
            rsum_next[r] = prod_reg[r][0] + prod_reg[r][1] + prod_reg[r][2];
        end
        value_next = rsum_reg[0] + rsum_reg[1] + rsum_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_free) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_free) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free) begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_free && in_valid) begin
            prod_reg  <= prod_next;
            meta1_reg <= in_entry.meta;
        end
        if (s2_free && s1_valid_reg) begin
            rsum_reg  <= rsum_next;
            meta2_reg <= meta1_reg;
        end
        if (out_free && s2_valid_reg) begin
            value_reg <= value_next;
            meta3_reg <= meta2_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(c3s_pkg::M_TDATA_BITS - c3s_pkg::M_FIELD_BITS){1'b0}},
                       meta3_reg.out_col, meta3_reg.out_row, value_reg};
    assign m_tlast  = meta3_reg.last;

endmodule

@@ rtl/core/conv3x3_stencil_stream_unit.sv @@
// ----------------------------------------------------------------------------
// conv3x3_stencil_stream_unit
// streaming 3x3 valid-region convolution over a row-major sample stream
// ----------------------------------------------------------------------------
// throughput: one sample per cycle unless m_tready stalls; line store rams take
//   a read and a write per cycle, the multiply pipeline a window per cycle
// path: front stage, queue slot, then product, row sum and output registers
// reset: counters, valids and queue pointers clear, coefficients go to zero,
//   line_width and image_height to 3; line store contents are left as they are
// ----------------------------------------------------------------------------
module conv3x3_stencil_stream_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // [15:0] sample
    input  logic [0:0]   s_tuser,   // [0] img_start
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // [31:0] value, [47:32] out_row, [57:48] out_col
    output logic         m_tlast,   // last result of the image
    // configuration writes
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_addr,
    input  logic [47:0]  cfg_wdata
);

    // configuration registers
    c3s_pkg::coef_set_t                coef_reg, coef_next;
    logic [c3s_pkg::LW_BITS-1:0]       line_width_reg, line_width_next;
    logic [c3s_pkg::ROW_BITS-1:0]      image_height_reg, image_height_next;

    // front to queue
    logic                              fe_valid, q_in_ready;
    c3s_pkg::q_entry_t                 fe_entry;
    // queue to back
    logic                              q_out_valid, be_ready;
    c3s_pkg::q_entry_t                 q_entry;
    c3s_pkg::q_status_t                q_status;
    logic                              q_push, q_pop;

    // register write decode, writes past the list are dropped
    always_comb begin
        coef_next         = coef_reg;
        line_width_next   = line_width_reg;
        image_height_next = image_height_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                c3s_pkg::CFG_COEF_TOP:     coef_next[0] = cfg_wdata;
                c3s_pkg::CFG_COEF_MID:     coef_next[1] = cfg_wdata;
                c3s_pkg::CFG_COEF_BOT:     coef_next[2] = cfg_wdata;
                c3s_pkg::CFG_LINE_WIDTH:   line_width_next = cfg_wdata[c3s_pkg::LW_BITS-1:0];
                c3s_pkg::CFG_IMAGE_HEIGHT: image_height_next =
                                               cfg_wdata[c3s_pkg::ROW_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg         <= '0;
            line_width_reg   <= c3s_pkg::LW_BITS'(3);
            image_height_reg <= c3s_pkg::ROW_BITS'(3);
        end else begin
            coef_reg         <= coef_next;
            line_width_reg   <= line_width_next;
            image_height_reg <= image_height_next;
        end
    end

    // front: counters, line stores, window
    c3s_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_sample      ($signed(s_tdata)),
        .in_img_start   (s_tuser[0]),
        .line_width     (line_width_reg),
        .image_height   (image_height_reg),
        .out_valid      (fe_valid),
        .out_ready      (q_in_ready),
        .out_entry      (fe_entry)
    );

    // windows that produce a result wait here for the back part
    c3s_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fe_valid),
        .in_ready  (q_in_ready),
        .in_entry  (fe_entry),
        .out_valid (q_out_valid),
        .out_ready (be_ready),
        .out_entry (q_entry),
        .status    (q_status)
    );

    // back: products and sum, drives the result channel
    c3s_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_out_valid),
        .in_ready (be_ready),
        .in_entry (q_entry),
        .coefs    (coef_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    assign q_push = fe_valid && q_in_ready;
    assign q_pop  = q_out_valid && be_ready;

    // no result and an empty queue right after reset
    a_reset_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> (!m_tvalid && q_status.empty))
        else $error("result or queued window right after reset");

    // queue fill follows push and pop
    a_queue_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && !q_pop) |=> (q_status.count == $past(q_status.count) + 1'b1))
        else $error("queue count did not grow on push");

    a_queue_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && !q_push) |=> (q_status.count == $past(q_status.count) - 1'b1))
        else $error("queue count did not shrink on pop");

    // a line width write lands in the register
    a_cfg_width: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wr_en && (cfg_addr == c3s_pkg::CFG_LINE_WIDTH))
        |=> (line_width_reg == $past(cfg_wdata[c3s_pkg::LW_BITS-1:0])))
        else $error("line width write lost");

endmodule
